// ===== design/wcr_pkg.sv =====
package wcr_pkg;

  localparam int LINEAR_INDEX_BITS_DEF   = 10;
  localparam int RATIO_FRACTION_BITS_DEF = 11;

  // linear channel value, Q16, 0 to 65536
  localparam int LIN_W = 17;

  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 32;
  localparam int MID_CW    = $clog2(MID_DEPTH) + 1;
  localparam int OUT_CW    = $clog2(OUT_DEPTH) + 1;

  localparam logic [15:0] WEIGHT_R   = 16'd13933;
  localparam logic [15:0] WEIGHT_G   = 16'd46871;
  localparam logic [15:0] WEIGHT_B   = 16'd4732;
  localparam logic [16:0] LUM_OFFSET = 17'd3277;

  typedef struct packed {
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [7:0] fg_alpha;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
  } in_item_t;

  typedef struct packed {
    logic [15:0] contrast_ratio;
    logic        below_minimum;
  } out_item_t;

  typedef logic [LIN_W-1:0] lin_t;

  typedef struct packed {
    lin_t fg_r;
    lin_t fg_g;
    lin_t fg_b;
    lin_t bg_r;
    lin_t bg_g;
    lin_t bg_b;
  } lin_set_t;

  typedef struct packed {
    logic              empty;
    logic [MID_CW-1:0] count;
  } mid_stat_t;

  typedef struct packed {
    logic              empty;
    logic [OUT_CW-1:0] count;
  } out_stat_t;

endpackage

// ===== design/wcr_lin_rom.sv =====
module wcr_lin_rom #(
  parameter int LINEAR_INDEX_BITS = wcr_pkg::LINEAR_INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic [LINEAR_INDEX_BITS-1:0] addr,
  output wcr_pkg::lin_t                rd_data
);

  localparam int Depth = 1 << LINEAR_INDEX_BITS;
  localparam logic [63:0] IdxMax = (64'd1 << LINEAR_INDEX_BITS) - 64'd1;

  // largest Q30 r with r^5 <= s, fifth power by truncating Q30 multiplies
  function automatic logic [63:0] root5_q30(input logic [63:0] s);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] x;
    lo = 64'd0;
    hi = 64'd1 << 30;
    for (int n = 0; n < 32; n++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        x = mid;
        for (int k = 0; k < 4; k++) begin
          x = (x * mid) >> 30;
        end
        if (x <= s) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return lo;
  endfunction

  wcr_pkg::lin_t rom_w [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_entry
    localparam logic [63:0] Idx    = 64'(i);
    localparam bit          IsLin  = (Idx * 64'd100000) <= (64'd3928 * IdxMax);
    localparam logic [63:0] LinVal = (Idx * 64'd6553600 + 64'd646 * IdxMax) /
                                     (64'd1292 * IdxMax);
    localparam logic [63:0] Tq     = (((Idx * 64'd1000 + 64'd55 * IdxMax) << 30) +
                                     (64'd1055 * IdxMax) / 64'd2) / (64'd1055 * IdxMax);
    localparam logic [63:0] Sq     = (Tq * Tq + (64'd1 << 29)) >> 30;
    localparam logic [63:0] Rq     = root5_q30(Sq);
    localparam logic [63:0] PwVal  = (Sq * Rq + (64'd1 << 43)) >> 44;
    assign rom_w[i] = IsLin ? LinVal[wcr_pkg::LIN_W-1:0] : PwVal[wcr_pkg::LIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    rd_data <= rom_w[addr];
  end

endmodule

// ===== design/wcr_fifo.sv =====
module wcr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  output logic [WIDTH-1:0]         rd_data,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = PW + 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    rd_addr_next;
  logic             bypass;

  assign empty        = (count == '0);
  assign rd_addr_next = rd_ptr + PW'(rd_en);
  // head comes straight from the write when the queue is (about to be) empty
  assign bypass       = wr_en && (empty || ((count == CW'(1)) && rd_en));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(wr_en) - CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    if (bypass) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr_next];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count != CW'(DEPTH)) || rd_en)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !empty)
    else $error("queue underflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    ##1 !$past(rst) |-> count == $past(count) + CW'($past(wr_en)) - CW'($past(rd_en)))
    else $error("queue count mismatch");

  a_fill_shows: assert property (@(posedge clk) disable iff (rst)
    (wr_en && empty) |=> !empty)
    else $error("written transaction not visible");

endmodule

// ===== design/wcr_front.sv =====
module wcr_front #(
  parameter int LINEAR_INDEX_BITS = wcr_pkg::LINEAR_INDEX_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  wcr_pkg::in_item_t  in_item,
  input  wcr_pkg::mid_stat_t mid_stat,
  output logic               mid_push,
  output wcr_pkg::lin_set_t  mid_data
);

  localparam int LB     = LINEAR_INDEX_BITS;
  localparam int VW     = LB + 16;
  localparam int RW     = LB + 1;
  localparam int PW     = VW + RW;
  localparam int Lanes  = 6;
  localparam int Stages = 6;
  localparam int IFW    = $clog2(Stages + 1);
  localparam int OW     = wcr_pkg::MID_CW + 1;

  localparam logic [VW-1:0] IdxMax    = VW'((64'd1 << LB) - 64'd1);
  localparam logic [VW-1:0] Round     = VW'(32512);
  localparam logic [VW-1:0] BlendFull = VW'(65025);
  localparam logic [RW-1:0] Recip     = RW'((64'd1 << VW) / 64'd65025);

  logic              accept;
  logic [Stages-1:0] vld;
  logic [OW-1:0]     occupancy;

  logic [7:0]    lane_fg [Lanes];
  logic [7:0]    lane_bg [Lanes];
  logic [7:0]    lane_a  [Lanes];
  logic [15:0]   blend   [Lanes];
  logic [VW-1:0] rem5    [Lanes];

  logic [15:0]   s1_b   [Lanes];
  logic [VW-1:0] s2_v   [Lanes];
  logic [PW-1:0] s3_p   [Lanes];
  logic [VW-1:0] s3_v   [Lanes];
  logic [LB-1:0] s4_q   [Lanes];
  logic [VW-1:0] s4_qm  [Lanes];
  logic [VW-1:0] s4_v   [Lanes];
  logic [LB-1:0] s5_idx [Lanes];
  wcr_pkg::lin_t rom_q  [Lanes];

  // items in flight are counted against the mid queue so nothing is ever dropped
  assign occupancy = OW'(IFW'($countones(vld))) + OW'(mid_stat.count);
  assign full      = occupancy >= OW'(wcr_pkg::MID_DEPTH);
  assign accept    = push && !full;

  // background lanes use the blend path with zero alpha
  always_comb begin
    lane_fg[0] = in_item.fg_red;   lane_bg[0] = in_item.bg_red;   lane_a[0] = in_item.fg_alpha;
    lane_fg[1] = in_item.fg_green; lane_bg[1] = in_item.bg_green; lane_a[1] = in_item.fg_alpha;
    lane_fg[2] = in_item.fg_blue;  lane_bg[2] = in_item.bg_blue;  lane_a[2] = in_item.fg_alpha;
    lane_fg[3] = 8'd0;             lane_bg[3] = in_item.bg_red;   lane_a[3] = 8'd0;
    lane_fg[4] = 8'd0;             lane_bg[4] = in_item.bg_green; lane_a[4] = 8'd0;
    lane_fg[5] = 8'd0;             lane_bg[5] = in_item.bg_blue;  lane_a[5] = 8'd0;
    for (int l = 0; l < Lanes; l++) begin
      blend[l] = lane_fg[l] * lane_a[l] + lane_bg[l] * (8'd255 - lane_a[l]);
      rem5[l]  = s4_v[l] - s4_qm[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Stages-2:0], accept};
    end
  end

  // index = round(blend * M / 65025): reciprocal estimate, then one correction step
  always_ff @(posedge clk) begin
    for (int l = 0; l < Lanes; l++) begin
      s1_b[l]   <= blend[l];
      s2_v[l]   <= VW'(s1_b[l]) * IdxMax + Round;
      s3_p[l]   <= PW'(s2_v[l]) * PW'(Recip);
      s3_v[l]   <= s2_v[l];
      s4_q[l]   <= s3_p[l][VW+LB-1:VW];
      s4_qm[l]  <= VW'(s3_p[l][VW+LB-1:VW]) * BlendFull;
      s4_v[l]   <= s3_v[l];
      s5_idx[l] <= (rem5[l] >= BlendFull) ? s4_q[l] + LB'(1) : s4_q[l];
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_rom
    wcr_lin_rom #(
      .LINEAR_INDEX_BITS(LB)
    ) u_rom (
      .clk    (clk),
      .addr   (s5_idx[l]),
      .rd_data(rom_q[l])
    );
  end

  assign mid_push      = vld[Stages-1];
  assign mid_data.fg_r = rom_q[0];
  assign mid_data.fg_g = rom_q[1];
  assign mid_data.fg_b = rom_q[2];
  assign mid_data.bg_r = rom_q[3];
  assign mid_data.bg_g = rom_q[4];
  assign mid_data.bg_b = rom_q[5];

endmodule

// ===== design/wcr_back.sv =====
module wcr_back #(
  parameter int RATIO_FRACTION_BITS = wcr_pkg::RATIO_FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        min_ratio,
  input  wcr_pkg::mid_stat_t mid_stat,
  input  wcr_pkg::lin_set_t  mid_data,
  output logic               mid_pop,
  input  wcr_pkg::out_stat_t out_stat,
  output logic               out_push,
  output wcr_pkg::out_item_t out_data
);

  localparam int F   = RATIO_FRACTION_BITS;
  localparam int QB  = F + 5;
  localparam int NW  = F + 18;
  localparam int DW  = QB + 17;
  localparam int LAT = QB + 3;
  localparam int IW  = $clog2(LAT + 1);
  localparam int SW  = wcr_pkg::OUT_CW + 1;

  logic [2:0]    b_vld;
  logic [QB-1:0] dv_vld;
  logic [SW-1:0] occupancy;

  logic [31:0] b1_p [6];
  logic [32:0] sum1;
  logic [32:0] sum2;
  logic [16:0] b2_y1;
  logic [16:0] b2_y2;
  logic [16:0] b3_hi;
  logic [16:0] b3_lo;
  logic [NW-1:0] num;

  logic [NW-1:0] dv_rem [QB];
  logic [16:0]   dv_lo  [QB];
  logic [QB-1:0] dv_q   [QB];
  logic [NW-1:0] rem_nx [QB];
  logic [QB-1:0] q_nx   [QB];
  logic [NW-1:0] rin;
  logic [16:0]   lin;
  logic [QB-1:0] qin;
  logic [DW-1:0] dvs;

  logic [QB+15:0] qx;
  logic [15:0]    ratio;

  assign occupancy = SW'(IW'($countones({b_vld, dv_vld}))) + SW'(out_stat.count);
  assign mid_pop   = !mid_stat.empty && (occupancy < SW'(wcr_pkg::OUT_DEPTH));

  always_comb begin
    sum1 = 33'(b1_p[0]) + 33'(b1_p[1]) + 33'(b1_p[2]) + 33'd32768;
    sum2 = 33'(b1_p[3]) + 33'(b1_p[4]) + 33'(b1_p[5]) + 33'd32768;
    num  = (NW'(b3_hi) << F) + NW'(b3_lo >> 1);
  end

  // restoring division, one quotient bit per stage, most significant first
  always_comb begin
    for (int s = 0; s < QB; s++) begin
      if (s == 0) begin
        rin = num;
        lin = b3_lo;
        qin = '0;
      end else begin
        rin = dv_rem[s-1];
        lin = dv_lo[s-1];
        qin = dv_q[s-1];
      end
      dvs     = DW'(lin) << (QB - 1 - s);
      q_nx[s] = qin;
      if (DW'(rin) >= dvs) begin
        rem_nx[s]          = NW'(DW'(rin) - dvs);
        q_nx[s][QB-1-s]    = 1'b1;
      end else begin
        rem_nx[s] = rin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld  <= '0;
      dv_vld <= '0;
    end else begin
      b_vld  <= {b_vld[1:0], mid_pop};
      dv_vld <= {dv_vld[QB-2:0], b_vld[2]};
    end
  end

  always_ff @(posedge clk) begin
    b1_p[0] <= wcr_pkg::WEIGHT_R * mid_data.fg_r;
    b1_p[1] <= wcr_pkg::WEIGHT_G * mid_data.fg_g;
    b1_p[2] <= wcr_pkg::WEIGHT_B * mid_data.fg_b;
    b1_p[3] <= wcr_pkg::WEIGHT_R * mid_data.bg_r;
    b1_p[4] <= wcr_pkg::WEIGHT_G * mid_data.bg_g;
    b1_p[5] <= wcr_pkg::WEIGHT_B * mid_data.bg_b;
    b2_y1   <= sum1[32:16];
    b2_y2   <= sum2[32:16];
    if (b2_y1 > b2_y2) begin
      b3_hi <= b2_y1 + wcr_pkg::LUM_OFFSET;
      b3_lo <= b2_y2 + wcr_pkg::LUM_OFFSET;
    end else begin
      b3_hi <= b2_y2 + wcr_pkg::LUM_OFFSET;
      b3_lo <= b2_y1 + wcr_pkg::LUM_OFFSET;
    end
    for (int s = 0; s < QB; s++) begin
      dv_rem[s] <= rem_nx[s];
      dv_q[s]   <= q_nx[s];
      dv_lo[s]  <= (s == 0) ? b3_lo : dv_lo[s-1];
    end
  end

  // saturate to 16 bits for wide fraction formats
  assign qx    = {16'd0, dv_q[QB-1]};
  assign ratio = (qx > (QB+16)'(16'hFFFF)) ? 16'hFFFF : qx[15:0];

  assign out_push                = dv_vld[QB-1];
  assign out_data.contrast_ratio = ratio;
  assign out_data.below_minimum  = ratio < min_ratio;

endmodule

// ===== design/wcag_contrast_ratio.sv =====
// WCAG contrast ratio of a foreground RGBA colour blended over a background RGB colour.
// Input channel: a queue write port. A transaction is taken on a rising edge with push
// high and full low; in_item carries the seven 8-bit channels.
// Result channel: a queue read port. While empty is low the oldest result is on out_item
// (contrast_ratio with RATIO_FRACTION_BITS fraction bits, below_minimum flag); it is
// taken on a rising edge with pop high.
// cfg_we writes cfg_wdata into the minimum ratio register; write it only while idle.
// Throughput: one transaction per cycle, sustained while the receiver keeps popping.
// From acceptance to a visible result, each transaction passes the front (index by
// reciprocal, table read), the mid queue, the back (weights, luminance, ordering, one
// quotient bit per divider stage) and then the result queue.
// If the receiver stalls, the back keeps running until the result queue plus the
// work in flight fill it, the mid queue then fills and full rises; nothing is lost.
// Reset (rst, synchronous) empties both queues, drops work in flight and clears the
// minimum ratio to zero.
module wcag_contrast_ratio #(
  parameter int LINEAR_INDEX_BITS   = wcr_pkg::LINEAR_INDEX_BITS_DEF,
  parameter int RATIO_FRACTION_BITS = wcr_pkg::RATIO_FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  wcr_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output wcr_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  localparam int MidW = $bits(wcr_pkg::lin_set_t);
  localparam int OutW = $bits(wcr_pkg::out_item_t);

  logic [15:0]        min_ratio;
  logic               mid_push;
  logic               mid_pop;
  wcr_pkg::lin_set_t  mid_wdata;
  wcr_pkg::lin_set_t  mid_rdata;
  wcr_pkg::mid_stat_t mid_stat;
  logic               out_push;
  wcr_pkg::out_item_t out_wdata;
  wcr_pkg::out_stat_t out_stat;
  logic               out_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_ratio <= '0;
    end else if (cfg_we) begin
      min_ratio <= cfg_wdata;
    end
  end

  wcr_front #(
    .LINEAR_INDEX_BITS(LINEAR_INDEX_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .mid_stat(mid_stat),
    .mid_push(mid_push),
    .mid_data(mid_wdata)
  );

  wcr_fifo #(
    .WIDTH(MidW),
    .DEPTH(wcr_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (mid_push),
    .wr_data(mid_wdata),
    .rd_en  (mid_pop),
    .rd_data(mid_rdata),
    .empty  (mid_stat.empty),
    .count  (mid_stat.count)
  );

  wcr_back #(
    .RATIO_FRACTION_BITS(RATIO_FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .min_ratio(min_ratio),
    .mid_stat (mid_stat),
    .mid_data (mid_rdata),
    .mid_pop  (mid_pop),
    .out_stat (out_stat),
    .out_push (out_push),
    .out_data (out_wdata)
  );

  assign out_pop = pop && !out_stat.empty;
  assign empty   = out_stat.empty;

  wcr_fifo #(
    .WIDTH(OutW),
    .DEPTH(wcr_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (out_push),
    .wr_data(out_wdata),
    .rd_en  (out_pop),
    .rd_data(out_item),
    .empty  (out_stat.empty),
    .count  (out_stat.count)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int IDX_BITS  = wcr_pkg::LINEAR_INDEX_BITS_DEF;
  localparam int FRAC_BITS = wcr_pkg::RATIO_FRACTION_BITS_DEF;
  localparam int IDX_TOP   = (1 << IDX_BITS) - 1;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_RANDOM  = 750;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  wcr_pkg::in_item_t in_item = '0;
  logic empty;
  logic pop = 0;
  wcr_pkg::out_item_t out_item;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = '0;

  int unsigned stall_cycles = 0;
  bit quiet_phase = 0;
  int idle_count = 0;

  always #5 clk = ~clk;

  wcag_contrast_ratio dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // linearised sRGB channel per index, Q16
  logic [31:0] lin_q16 [0:IDX_TOP];

  function automatic longint unsigned pow5_q30(longint unsigned r);
    longint unsigned x;
    x = r;
    for (int k = 0; k < 4; k++) x = (x * r) >> 30;
    return x;
  endfunction

  function automatic logic [31:0] srgb_to_linear(int unsigned i);
    longint unsigned m, t, s, lo, hi, mid;
    m = IDX_TOP;
    if (longint'(i) * 100000 <= 3928 * m)
      return 32'((longint'(i) * 6553600 + 646 * m) / (1292 * m));
    t = (((longint'(i) * 1000 + 55 * m) << 30) + (1055 * m) / 2) / (1055 * m);
    s = (t * t + (64'd1 << 29)) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (pow5_q30(mid) <= s) lo = mid;
      else hi = mid - 1;
    end
    return 32'((s * lo + (64'd1 << 43)) >> 44);
  endfunction

  function automatic int unsigned lin_of(longint unsigned blended);
    return lin_q16[((blended * IDX_TOP + 32512) / 65025) & IDX_TOP];
  endfunction

  function automatic longint unsigned rel_luminance(longint unsigned r, longint unsigned g,
                                                    longint unsigned b);
    longint unsigned sum;
    sum = 13933 * longint'(lin_of(r)) + 46871 * longint'(lin_of(g))
        + 4732 * longint'(lin_of(b));
    return (sum + 32768) >> 16;
  endfunction

  class ratio_scoreboard;
    wcr_pkg::out_item_t pending[$];
    logic [15:0] min_ratio;
    int errors;

    function new();
      min_ratio = '0;
      errors = 0;
    endfunction

    function void note_pair(wcr_pkg::in_item_t it);
      longint unsigned a, na, y_blend, y_bg, hi, lo, r;
      wcr_pkg::out_item_t exp_res;
      a = it.fg_alpha;
      na = 255 - a;
      y_blend = rel_luminance(it.fg_red * a + it.bg_red * na,
                              it.fg_green * a + it.bg_green * na,
                              it.fg_blue * a + it.bg_blue * na);
      y_bg = rel_luminance(it.bg_red * 255, it.bg_green * 255, it.bg_blue * 255);
      hi = (y_blend > y_bg ? y_blend : y_bg) + 3277;
      lo = (y_blend > y_bg ? y_bg : y_blend) + 3277;
      r = ((hi << FRAC_BITS) + lo / 2) / lo;
      if (r > 65535) r = 65535;
      exp_res.contrast_ratio = r[15:0];
      exp_res.below_minimum = (r < min_ratio);
      pending.push_back(exp_res);
    endfunction

    function void check_result(wcr_pkg::out_item_t got);
      wcr_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $error("result with none expected: ratio %0d", got.contrast_ratio);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.contrast_ratio !== e.contrast_ratio) begin
        $error("contrast_ratio expected %0d actual %0d", e.contrast_ratio, got.contrast_ratio);
        errors++;
      end
      if (got.below_minimum !== e.below_minimum) begin
        $error("below_minimum expected %0d actual %0d", e.below_minimum, got.below_minimum);
        errors++;
      end
    endfunction
  endclass

  ratio_scoreboard sb;

  // receiver: random pops, one long hold-off, a quiet stretch
  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) sb.check_result(out_item);
      if (stall_cycles > 0) begin
        stall_cycles <= stall_cycles - 1;
        pop <= 0;
      end else begin
        pop <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // push is left high after the transaction; idling and drain lower it
  task automatic send_pair(wcr_pkg::in_item_t it);
    while (!quiet_phase && $urandom_range(99) < 27) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_pair(it);
  endtask

  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (FRAC_BITS + 25) @(posedge clk);
  endtask

  task automatic set_minimum(logic [15:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.min_ratio = v;
  endtask

  function automatic wcr_pkg::in_item_t rand_pair();
    wcr_pkg::in_item_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[55:0];
    case ($urandom_range(5))
      0: it.fg_alpha = 8'd255;
      1: it.fg_alpha = 8'd0;
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    logic [15:0] minimums [4];
    sb = new();
    for (int i = 0; i <= IDX_TOP; i++) lin_q16[i] = srgb_to_linear(i);
    minimums = '{16'd0, 16'd43008, 16'd9216, 16'hFFFF};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: black/white both ways, alpha extremes, linear-segment knee, grey
    set_minimum(16'd9216);
    send_pair('{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
    send_pair('{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0});
    send_pair('{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
    send_pair('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_pair('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    send_pair('{8'd255, 8'd0, 8'd0, 8'd128, 8'd0, 8'd255, 8'd0});
    send_pair('{8'd0, 8'd0, 8'd255, 8'd1, 8'd255, 8'd255, 8'd0});
    send_pair('{8'd10, 8'd11, 8'd9, 8'd255, 8'd10, 8'd11, 8'd9});
    send_pair('{8'd119, 8'd119, 8'd119, 8'd255, 8'd255, 8'd255, 8'd255});
    send_pair('{8'd170, 8'd85, 8'd51, 8'd254, 8'd85, 8'd170, 8'd204});
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_minimum(minimums[ph]);
      if (ph == 1) stall_cycles = 400;
      quiet_phase = (ph == 2);
      for (int n = 0; n < N_RANDOM / 4; n++) send_pair(rand_pair());
      quiet_phase = 0;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
